>>> design/tcb_spline_point_eval_unit_macros.svh
`ifndef TCB_SPLINE_POINT_EVAL_UNIT_MACROS_SVH
`define TCB_SPLINE_POINT_EVAL_UNIT_MACROS_SVH

// overlapping implication, off while in reset
`define TCBSPL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error(msg);

// next-cycle implication, also checked through reset
`define TCBSPL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/tcbspl_pkg.sv
package tcbspl_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 15;
    localparam int OUT_WIDTH   = COORD_WIDTH + 3;

    // weight factors 0 .. 2*ONE, their products, rounded weights
    localparam int FACT_W = FRAC_BITS + 2;
    localparam int PAIR_W = 2 * FACT_W;
    localparam int PROD_W = 3 * FACT_W;
    localparam int K_W    = FRAC_BITS + 3;

    // basis
    localparam int T_W    = COORD_WIDTH;
    localparam int POLY_W = 3 * T_W + 4;
    localparam int H_W    = FRAC_BITS + 5;

    // coordinate datapath
    localparam int D_W    = COORD_WIDTH + 1;
    localparam int KD_W   = K_W + 1 + D_W;
    localparam int TAN_W  = KD_W + 1;
    localparam int QH_W   = COORD_WIDTH + H_W;
    localparam int QS_W   = QH_W + 1;
    localparam int TH_W   = TAN_W + H_W;
    localparam int ACC_W  = TH_W + 2;

    localparam int PIPE_DEPTH = 7;

    typedef struct packed {
        logic [K_W-1:0] k0;
        logic [K_W-1:0] k1;
        logic [K_W-1:0] k2;
        logic [K_W-1:0] k3;
    } t_weights;

    typedef struct packed {
        logic signed [H_W-1:0] h0;
        logic signed [H_W-1:0] h1;
        logic signed [H_W-1:0] h2;
        logic signed [H_W-1:0] h3;
    } t_basis;

endpackage

>>> design/tcb_spline_point_eval_unit.sv
// Kochanek-Bartels spline point, x and z per transaction.
// Each accepted start shifts through the valid pipe r_vld, whose last stage drives o_strobe with o_curve_x/z.
// Throughput: one transaction per cycle; busy is always low, seven in flight.
// Seven register stages, the widest being the 37x20 tangent-by-basis multiply.
// Synchronous active-low reset clears the valid pipe; transactions in flight are dropped.
`include "tcb_spline_point_eval_unit_macros.svh"

module tcb_spline_point_eval_unit import tcbspl_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_p1_x,
    input  logic signed [COORD_WIDTH-1:0] i_p1_z,
    input  logic signed [COORD_WIDTH-1:0] i_p2_x,
    input  logic signed [COORD_WIDTH-1:0] i_p2_z,
    input  logic signed [COORD_WIDTH-1:0] i_p3_x,
    input  logic signed [COORD_WIDTH-1:0] i_p3_z,
    input  logic signed [COORD_WIDTH-1:0] i_p4_x,
    input  logic signed [COORD_WIDTH-1:0] i_p4_z,
    input  logic [COORD_WIDTH-1:0]        i_param_t,
    input  logic signed [COORD_WIDTH-1:0] i_tension,
    input  logic signed [COORD_WIDTH-1:0] i_bias,
    input  logic signed [COORD_WIDTH-1:0] i_continuity,
    output logic                          o_strobe,
    output logic signed [OUT_WIDTH-1:0]   o_curve_x,
    output logic signed [OUT_WIDTH-1:0]   o_curve_z
);

    t_weights              weights;
    t_basis                basis;
    logic [PIPE_DEPTH-1:0] n_vld, r_vld;

    assign busy  = 1'b0;
    assign n_vld = {r_vld[PIPE_DEPTH-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_strobe = r_vld[PIPE_DEPTH-1];

    tcbspl_weights u_weights (
        .i_clk        (i_clk),
        .i_tension    (i_tension),
        .i_bias       (i_bias),
        .i_continuity (i_continuity),
        .o_weights    (weights)
    );

    tcbspl_basis u_basis (
        .i_clk     (i_clk),
        .i_param_t (i_param_t),
        .o_basis   (basis)
    );

    tcbspl_coord u_coord_x (
        .i_clk     (i_clk),
        .i_q1      (i_p1_x),
        .i_q2      (i_p2_x),
        .i_q3      (i_p3_x),
        .i_q4      (i_p4_x),
        .i_weights (weights),
        .i_basis   (basis),
        .o_curve   (o_curve_x)
    );

    tcbspl_coord u_coord_z (
        .i_clk     (i_clk),
        .i_q1      (i_p1_z),
        .i_q2      (i_p2_z),
        .i_q3      (i_p3_z),
        .i_q4      (i_p4_z),
        .i_weights (weights),
        .i_basis   (basis),
        .o_curve   (o_curve_z)
    );

    `TCBSPL_ASSERT_IMP(a_latency, start && !busy, ##PIPE_DEPTH o_strobe, "transaction lost in pipe")
    `TCBSPL_ASSERT_IMP(a_source, o_strobe, $past(start && !busy, PIPE_DEPTH), "strobe without transaction")
    `TCBSPL_ASSERT_NEXT(a_reset, !i_rst_n, !o_strobe && (r_vld == '0), "valid pipe not cleared by reset")

endmodule

>>> design/tcbspl_weights.sv
module tcbspl_weights import tcbspl_pkg::*; (
    input  logic                          i_clk,
    input  logic signed [COORD_WIDTH-1:0] i_tension,
    input  logic signed [COORD_WIDTH-1:0] i_bias,
    input  logic signed [COORD_WIDTH-1:0] i_continuity,
    output t_weights                      o_weights
);

    localparam logic signed [FACT_W:0] ONE_S  = (FACT_W+1)'(2**FRAC_BITS);
    localparam logic [PROD_W:0]        K_HALF = (PROD_W+1)'(1) << (2*FRAC_BITS);

    function automatic logic [K_W-1:0] round_weight(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] s;
        s = {1'b0, p} + K_HALF;
        return s[2*FRAC_BITS+1 +: K_W];
    endfunction

    logic signed [FACT_W:0] ft_s, bp_s, bm_s, cp_s, cm_s;
    logic [FACT_W-1:0]      ft, bp, bm;
    logic [PAIR_W-1:0]      n_ftbp, n_ftbm;
    logic [PAIR_W-1:0]      r_ftbp, r_ftbm;
    logic [FACT_W-1:0]      r_cp, r_cm;
    logic [PROD_W-1:0]      r_p0, r_p1, r_p2, r_p3;
    t_weights               n_weights, r_weights;

    always_comb begin
        ft_s = ONE_S - (FACT_W+1)'(i_tension);
        bp_s = ONE_S + (FACT_W+1)'(i_bias);
        bm_s = ONE_S - (FACT_W+1)'(i_bias);
        cp_s = ONE_S + (FACT_W+1)'(i_continuity);
        cm_s = ONE_S - (FACT_W+1)'(i_continuity);
        ft = ft_s[FACT_W-1:0];
        bp = bp_s[FACT_W-1:0];
        bm = bm_s[FACT_W-1:0];
        n_ftbp = ft * bp;
        n_ftbm = ft * bm;
    end

    always_comb begin
        n_weights.k0 = round_weight(r_p0);
        n_weights.k1 = round_weight(r_p1);
        n_weights.k2 = round_weight(r_p2);
        n_weights.k3 = round_weight(r_p3);
    end

    always_ff @(posedge i_clk) begin
        r_ftbp    <= n_ftbp;
        r_ftbm    <= n_ftbm;
        r_cp      <= cp_s[FACT_W-1:0];
        r_cm      <= cm_s[FACT_W-1:0];
        r_p0      <= r_ftbp * r_cp;
        r_p1      <= r_ftbm * r_cm;
        r_p2      <= r_ftbp * r_cm;
        r_p3      <= r_ftbm * r_cp;
        r_weights <= n_weights;
    end

    assign o_weights = r_weights;

endmodule

>>> design/tcbspl_basis.sv
module tcbspl_basis import tcbspl_pkg::*; (
    input  logic           i_clk,
    input  logic [T_W-1:0] i_param_t,
    output t_basis         o_basis
);

    localparam logic signed [POLY_W-1:0] H_HALF = POLY_W'(1) << (2*FRAC_BITS - 1);
    localparam logic signed [POLY_W-1:0] ONE3   = POLY_W'(1) << (3*FRAC_BITS);

    // half away from zero: (p + half - sign) >>> 2F
    function automatic logic signed [H_W-1:0] round_basis(
        input logic signed [POLY_W-1:0] p
    );
        logic signed [POLY_W-1:0] q;
        q = p + H_HALF - $signed({{(POLY_W-1){1'b0}}, p[POLY_W-1]});
        return q[2*FRAC_BITS +: H_W];
    endfunction

    logic [T_W-1:0]           r_t_s1, r_t_s2;
    logic [2*T_W-1:0]         r_t2_s1, r_t2_s2;
    logic [3*T_W-1:0]         r_t3;
    logic signed [POLY_W-1:0] s3, u2, v1, p0, p1, p2, p3;
    t_basis                   n_basis, r_basis;

    always_comb begin
        s3 = $signed(POLY_W'(r_t3));
        u2 = $signed(POLY_W'(r_t2_s2)) <<< FRAC_BITS;
        v1 = $signed(POLY_W'(r_t_s2)) <<< (2*FRAC_BITS);
        p0 = 2 * s3 - 3 * u2 + ONE3;
        p1 = 3 * u2 - 2 * s3;
        p2 = s3 - 2 * u2 + v1;
        p3 = s3 - u2;
        n_basis.h0 = round_basis(p0);
        n_basis.h1 = round_basis(p1);
        n_basis.h2 = round_basis(p2);
        n_basis.h3 = round_basis(p3);
    end

    always_ff @(posedge i_clk) begin
        r_t_s1  <= i_param_t;
        r_t2_s1 <= i_param_t * i_param_t;
        r_t_s2  <= r_t_s1;
        r_t2_s2 <= r_t2_s1;
        r_t3    <= r_t2_s1 * r_t_s1;
        r_basis <= n_basis;
    end

    assign o_basis = r_basis;

endmodule

>>> design/tcbspl_coord.sv
module tcbspl_coord import tcbspl_pkg::*; (
    input  logic                          i_clk,
    input  logic signed [COORD_WIDTH-1:0] i_q1,
    input  logic signed [COORD_WIDTH-1:0] i_q2,
    input  logic signed [COORD_WIDTH-1:0] i_q3,
    input  logic signed [COORD_WIDTH-1:0] i_q4,
    input  t_weights                      i_weights,
    input  t_basis                        i_basis,
    output logic signed [OUT_WIDTH-1:0]   o_curve
);

    localparam logic signed [ACC_W-1:0] A_HALF  = ACC_W'(1) << (2*FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(2**(OUT_WIDTH-1) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - ACC_W'(1);

    typedef struct packed {
        logic signed [D_W-1:0]         d21;
        logic signed [D_W-1:0]         d32;
        logic signed [D_W-1:0]         d43;
        logic signed [COORD_WIDTH-1:0] q2;
        logic signed [COORD_WIDTH-1:0] q3;
    } t_pts;

    t_pts                     n_pts, r_pts_s1, r_pts_s2, r_pts_s3;
    logic signed [K_W:0]      k0s, k1s, k2s, k3s;
    logic signed [KD_W-1:0]   r_m0, r_m1, r_m2, r_m3;
    logic signed [QH_W-1:0]   r_qh2, r_qh3;
    logic signed [H_W-1:0]    r_h2_s4, r_h3_s4, r_h2_s5, r_h3_s5;
    logic signed [TAN_W-1:0]  r_tan_a, r_tan_b;
    logic signed [QS_W-1:0]   r_qs_s5, r_qs_s6;
    logic signed [TH_W-1:0]   r_pa, r_pb;
    logic signed [ACC_W-1:0]  acc, rnd, shf;
    logic signed [OUT_WIDTH-1:0] n_curve, r_curve;

    always_comb begin
        n_pts.d21 = D_W'(i_q2) - D_W'(i_q1);
        n_pts.d32 = D_W'(i_q3) - D_W'(i_q2);
        n_pts.d43 = D_W'(i_q4) - D_W'(i_q3);
        n_pts.q2  = i_q2;
        n_pts.q3  = i_q3;
        k0s = $signed({1'b0, i_weights.k0});
        k1s = $signed({1'b0, i_weights.k1});
        k2s = $signed({1'b0, i_weights.k2});
        k3s = $signed({1'b0, i_weights.k3});
    end

    always_comb begin
        acc = (ACC_W'(r_qs_s6) <<< FRAC_BITS) + ACC_W'(r_pa) + ACC_W'(r_pb);
        rnd = acc + A_HALF - $signed({{(ACC_W-1){1'b0}}, acc[ACC_W-1]});
        shf = rnd >>> (2*FRAC_BITS);
        if (shf > OUT_MAX) begin
            n_curve = OUT_MAX[OUT_WIDTH-1:0];
        end else if (shf < OUT_MIN) begin
            n_curve = OUT_MIN[OUT_WIDTH-1:0];
        end else begin
            n_curve = shf[OUT_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pts_s1 <= n_pts;
        r_pts_s2 <= r_pts_s1;
        r_pts_s3 <= r_pts_s2;
        // tangent weights times differences, points times basis
        r_m0     <= k0s * r_pts_s3.d21;
        r_m1     <= k1s * r_pts_s3.d32;
        r_m2     <= k2s * r_pts_s3.d32;
        r_m3     <= k3s * r_pts_s3.d43;
        r_qh2    <= r_pts_s3.q2 * i_basis.h0;
        r_qh3    <= r_pts_s3.q3 * i_basis.h1;
        r_h2_s4  <= i_basis.h2;
        r_h3_s4  <= i_basis.h3;
        r_tan_a  <= TAN_W'(r_m0) + TAN_W'(r_m1);
        r_tan_b  <= TAN_W'(r_m2) + TAN_W'(r_m3);
        r_qs_s5  <= QS_W'(r_qh2) + QS_W'(r_qh3);
        r_h2_s5  <= r_h2_s4;
        r_h3_s5  <= r_h3_s4;
        r_pa     <= r_tan_a * r_h2_s5;
        r_pb     <= r_tan_b * r_h3_s5;
        r_qs_s6  <= r_qs_s5;
        r_curve  <= n_curve;
    end

    assign o_curve = r_curve;

endmodule
